### rtl/abb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package abb_pkg;

   localparam int MAX_SURFACE_DIM = 4096;
   localparam int BYTES_PER_PIXEL = 4;

   localparam int DIM_W  = $clog2(MAX_SURFACE_DIM);
   localparam int SIZE_W = DIM_W + 1;
   localparam int PIX_W  = 32;
   localparam int IDX_W  = 24;
   localparam int BYTE_W = 8;
   localparam int POS_W  = $clog2(BYTES_PER_PIXEL);
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = SIZE_W;

   localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [BYTE_W-1:0] BYTE_MAX     = 8'hFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BLEND_ENABLE       = 3'd0,
      CSR_CHANNEL_ORDER      = 3'd1,
      CSR_RECT_WIDTH         = 3'd2,
      CSR_RECT_HEIGHT        = 3'd3,
      CSR_DEST_SURFACE_WIDTH = 3'd4,
      CSR_DEST_ORIGIN_X      = 3'd5,
      CSR_DEST_ORIGIN_Y      = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_COPY   = 2'd0,
      MODE_BLEND  = 2'd1,
      MODE_OPAQUE = 2'd2
   } chan_mode_type;

   typedef struct packed {
      logic [SIZE_W-1:0] rect_width;
      logic [SIZE_W-1:0] rect_height;
      logic [SIZE_W-1:0] surf_width;
      logic [DIM_W-1:0]  origin_x;
      logic [DIM_W-1:0]  origin_y;
   } geom_type;

   typedef struct packed {
      logic [PIX_W-1:0] src;
      logic [PIX_W-1:0] px;
      logic [IDX_W-1:0] idx;
      logic             last;
   } pix_item_type;

   function automatic logic [BYTE_W-1:0] get_byte(input logic [PIX_W-1:0] px,
                                                  input logic [POS_W-1:0] pos);
      return px[{pos, 3'b000} +: BYTE_W];
   endfunction

   function automatic logic [PIX_W-1:0] put_byte(input logic [PIX_W-1:0] px,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [BYTE_W-1:0] v);
      logic [PIX_W-1:0] r;
      r = px;
      r[{pos, 3'b000} +: BYTE_W] = v;
      return r;
   endfunction

   // floor(x / 255) for x up to 255*255 as (x + 1 + (x >> 8)) >> 8
   function automatic logic [BYTE_W-1:0] blend_byte(input logic [BYTE_W-1:0] d,
                                                    input logic [BYTE_W-1:0] s,
                                                    input logic [BYTE_W-1:0] a);
      logic [2*BYTE_W:0] x;
      logic [2*BYTE_W:0] q;
      x = (2*BYTE_W+1)'(d * (BYTE_MAX - a)) + (2*BYTE_W+1)'(s * a);
      q = x + (2*BYTE_W+1)'(1) + (x >> BYTE_W);
      return q[2*BYTE_W-1:BYTE_W];
   endfunction

   function automatic logic [SIZE_W-1:0] clamp_dim(input logic [SIZE_W-1:0] v);
      if (v == '0) begin
         return SIZE_W'(1);
      end else if (v > SIZE_W'(MAX_SURFACE_DIM)) begin
         return SIZE_W'(MAX_SURFACE_DIM);
      end else begin
         return v;
      end
   endfunction

endpackage

`default_nettype wire

### rtl/abb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module abb_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire abb_pkg::geom_type         geom,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire logic [abb_pkg::PIX_W-1:0] in_src,
   input  wire logic [abb_pkg::PIX_W-1:0] in_dst,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output abb_pkg::pix_item_type          out_item
);

   localparam int PROD_W = 2 * abb_pkg::SIZE_W;

   logic [abb_pkg::DIM_W-1:0]  col_ff, col_in;
   logic [abb_pkg::DIM_W-1:0]  row_ff, row_in;
   logic                       valid_ff, valid_in;
   abb_pkg::pix_item_type      item_ff, item_in;

   logic [abb_pkg::SIZE_W-1:0] w_clamped, h_clamped;
   logic [abb_pkg::DIM_W-1:0]  w_last, h_last;
   logic                       col_end, row_end;
   logic [abb_pkg::DIM_W:0]    row_abs;
   logic [PROD_W-1:0]          line_start;
   logic                       accept;

   assign in_ready  = !valid_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      w_clamped = abb_pkg::clamp_dim(geom.rect_width);
      h_clamped = abb_pkg::clamp_dim(geom.rect_height);
      w_last    = abb_pkg::DIM_W'(w_clamped - abb_pkg::SIZE_W'(1));
      h_last    = abb_pkg::DIM_W'(h_clamped - abb_pkg::SIZE_W'(1));
      col_end   = col_ff >= w_last;
      row_end   = row_ff >= h_last;

      row_abs    = {1'b0, geom.origin_y} + {1'b0, row_ff};
      line_start = PROD_W'(row_abs) * PROD_W'(geom.surf_width);

      item_in.src  = in_src;
      item_in.px   = in_dst;
      item_in.idx  = abb_pkg::IDX_W'(line_start + PROD_W'(geom.origin_x) + PROD_W'(col_ff));
      item_in.last = col_end && row_end;

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + abb_pkg::DIM_W'(1);
         end else begin
            col_in = col_ff + abb_pkg::DIM_W'(1);
         end
      end

      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

### rtl/abb_chan_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module abb_chan_stage (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [abb_pkg::POS_W-1:0] pos,
   input  wire logic [abb_pkg::POS_W-1:0] alpha_pos,
   input  wire abb_pkg::chan_mode_type    mode,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire abb_pkg::pix_item_type     in_item,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output abb_pkg::pix_item_type          out_item
);

   logic                        valid_ff, valid_in;
   abb_pkg::pix_item_type       item_ff, item_in;
   logic [abb_pkg::BYTE_W-1:0]  a, d, s, v;
   logic                        accept;

   assign in_ready  = !valid_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   // d comes from the pixel as left by earlier channels, so colliding positions chain
   always_comb begin
      a = abb_pkg::get_byte(in_item.src, alpha_pos);
      d = abb_pkg::get_byte(in_item.px, pos);
      s = abb_pkg::get_byte(in_item.src, pos);
      case (mode)
         abb_pkg::MODE_COPY:   v = s;
         abb_pkg::MODE_BLEND:  v = abb_pkg::blend_byte(d, s, a);
         abb_pkg::MODE_OPAQUE: v = abb_pkg::ALPHA_OPAQUE;
         default:              v = s;
      endcase
      item_in    = in_item;
      item_in.px = abb_pkg::put_byte(in_item.px, pos, v);
      valid_in   = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

### rtl/alpha_blend_blit.sv
`timescale 1ns / 1ps
`default_nettype none

// Rectangle blit with optional alpha blend over 32-bit four-channel pixels. Each req transaction
// carries a source pixel and the destination pixel it lands on, in raster order over the
// rectangle; each rsp transaction returns the new destination pixel, its linear index in the
// destination surface and tlast on the final pixel of the rectangle. One pixel pair is taken
// every cycle unless rsp_tready back-pressure has filled the pipe. Each pixel passes through
// a registered stage for the column/row counters and the index multiply, then one stage per
// channel (red, green, blue, alpha), each colour stage holding a single 8x8 blend and the
// alpha stage forcing alpha opaque or copying it. Every stage has its own valid flag, so bubbles
// close up under back-pressure. Write the csr registers only while no pixel is in flight;
// counters keep their values across writes and restart after each tlast.

module alpha_blend_blit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [63:0]                     req_tdata,  // source_pixel, current_dest_pixel
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [55:0]                          rsp_tdata,  // result_pixel, dest_pixel_index
   output logic                                 rsp_tlast,
   input  wire logic                            csr_we,
   input  wire logic [abb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [abb_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int NSTAGE = abb_pkg::BYTES_PER_PIXEL;

   logic                        blend_en_ff;
   logic [7:0]                  channel_order_ff;
   abb_pkg::geom_type           geom_ff;

   logic                        valid [0:NSTAGE];
   logic                        ready [0:NSTAGE];
   abb_pkg::pix_item_type       item  [0:NSTAGE];

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_en_ff         <= 1'b0;
         channel_order_ff    <= 8'd228;
         geom_ff.rect_width  <= abb_pkg::SIZE_W'(1);
         geom_ff.rect_height <= abb_pkg::SIZE_W'(1);
         geom_ff.surf_width  <= abb_pkg::SIZE_W'(1);
         geom_ff.origin_x    <= '0;
         geom_ff.origin_y    <= '0;
      end else if (csr_we) begin
         case (abb_pkg::csr_index_type'(csr_index))
            abb_pkg::CSR_BLEND_ENABLE:       blend_en_ff         <= csr_wdata[0];
            abb_pkg::CSR_CHANNEL_ORDER:      channel_order_ff    <= csr_wdata[7:0];
            abb_pkg::CSR_RECT_WIDTH:         geom_ff.rect_width  <= csr_wdata;
            abb_pkg::CSR_RECT_HEIGHT:        geom_ff.rect_height <= csr_wdata;
            abb_pkg::CSR_DEST_SURFACE_WIDTH: geom_ff.surf_width  <= csr_wdata;
            abb_pkg::CSR_DEST_ORIGIN_X:
               geom_ff.origin_x <= csr_wdata[abb_pkg::DIM_W-1:0];
            abb_pkg::CSR_DEST_ORIGIN_Y:
               geom_ff.origin_y <= csr_wdata[abb_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
   end

   abb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .geom      (geom_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_src    (req_tdata[31:0]),
      .in_dst    (req_tdata[63:32]),
      .out_valid (valid[0]),
      .out_ready (ready[0]),
      .out_item  (item[0])
   );

   // channels in order red, green, blue, alpha; every blend reads alpha from the source pixel
   for (genvar c = 0; c < NSTAGE; c++) begin : g_chan
      abb_pkg::chan_mode_type mode;

      if (c == NSTAGE - 1) begin : g_alpha
         assign mode = blend_en_ff ? abb_pkg::MODE_OPAQUE : abb_pkg::MODE_COPY;
      end else begin : g_colour
         assign mode = blend_en_ff ? abb_pkg::MODE_BLEND : abb_pkg::MODE_COPY;
      end

      abb_chan_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .pos       (channel_order_ff[2*c +: 2]),
         .alpha_pos (channel_order_ff[7:6]),
         .mode      (mode),
         .in_valid  (valid[c]),
         .in_ready  (ready[c]),
         .in_item   (item[c]),
         .out_valid (valid[c+1]),
         .out_ready (ready[c+1]),
         .out_item  (item[c+1])
      );
   end

   assign ready[NSTAGE] = rsp_tready;
   assign rsp_tvalid    = valid[NSTAGE];
   assign rsp_tdata     = {item[NSTAGE].idx, item[NSTAGE].px};
   assign rsp_tlast     = item[NSTAGE].last;

   // the pipe only refuses input when every stage is full and the output is stalled
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled while pipeline has room");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && blend_en_ff) |->
         (abb_pkg::get_byte(rsp_tdata[31:0], channel_order_ff[7:6]) == abb_pkg::ALPHA_OPAQUE))
      else $error("blended pixel alpha not opaque");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

endmodule

`default_nettype wire
